FILE: sv/vcar_pkg.sv
// ----------------------------------------------------------------------------
// vcar_pkg
// Shared types, constants and coefficient tables for the voxel cube rotator.
// ----------------------------------------------------------------------------
package vcar_pkg;

	localparam int COEF_FRACTION_BITS = 14;
	localparam int COEF_W             = COEF_FRACTION_BITS + 2;
	localparam int SUM_W              = COEF_FRACTION_BITS + 4;
	localparam int ACC_W              = COEF_FRACTION_BITS + 5;
	localparam int Q_W                = ACC_W - COEF_FRACTION_BITS - 1;

	localparam logic signed [COEF_W-1:0] COEF_ONE  =
		COEF_W'(longint'(1) << COEF_FRACTION_BITS);
	localparam logic signed [COEF_W-1:0] COEF_866  =
		COEF_W'((866 * (longint'(1) << COEF_FRACTION_BITS) + 500) / 1000);
	localparam logic signed [COEF_W-1:0] COEF_HALF =
		COEF_W'(longint'(1) << (COEF_FRACTION_BITS - 1));

	// 1.5 and 0.5 at scale 2^(F+1)
	localparam logic signed [ACC_W-1:0] ACC_CENTER =
		ACC_W'(longint'(3) << COEF_FRACTION_BITS);
	localparam logic signed [ACC_W-1:0] ACC_ROUND =
		ACC_W'(longint'(1) << COEF_FRACTION_BITS);

	localparam logic [3:0] ANGLE_MAX = 4'd11;
	localparam logic [5:0] LAST_VOXEL = 6'd63;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z,
		AXIS_BAD
	} axis_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VISIT,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic visit;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic req_bad;
		logic last_voxel;
	} status_t;

	// cosine as a code: +-3 = 1.0, +-2 = .866, +-1 = .5, 0 = 0
	function automatic logic signed [2:0] cos_code(input logic [3:0] k);
		logic signed [2:0] c;
		case (k)
			4'd0:    c = 3'sd3;
			4'd1:    c = 3'sd2;
			4'd2:    c = 3'sd1;
			4'd3:    c = 3'sd0;
			4'd4:    c = -3'sd1;
			4'd5:    c = -3'sd2;
			4'd6:    c = -3'sd3;
			4'd7:    c = -3'sd2;
			4'd8:    c = -3'sd1;
			4'd9:    c = 3'sd0;
			4'd10:   c = 3'sd1;
			4'd11:   c = 3'sd2;
			default: c = 3'sd0;
		endcase
		return c;
	endfunction

	// (k + 9) mod 12 for k in 0..11
	function automatic logic [3:0] sin_index(input logic [3:0] k);
		logic [3:0] r;
		if (k >= 4'd3) begin
			r = k - 4'd3;
		end else begin
			r = k + 4'd9;
		end
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_of(input logic signed [2:0] code);
		logic signed [COEF_W-1:0] c;
		case (code)
			3'sd3:   c = COEF_ONE;
			3'sd2:   c = COEF_866;
			3'sd1:   c = COEF_HALF;
			-3'sd1:  c = -COEF_HALF;
			-3'sd2:  c = -COEF_866;
			-3'sd3:  c = -COEF_ONE;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/vcar_ctrl.sv
// ----------------------------------------------------------------------------
// vcar_ctrl
// Sequencer: takes a request, steps the voxel walk, drains, loads the result.
// ----------------------------------------------------------------------------
module vcar_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  vcar_pkg::status_t    status,
	output vcar_pkg::cmd_t       cmd
);

	vcar_pkg::state_t state_q;
	vcar_pkg::state_t state_nxt;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vcar_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			vcar_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = status.req_bad ? vcar_pkg::ST_FINISH : vcar_pkg::ST_VISIT;
				end
			end
			vcar_pkg::ST_VISIT: begin
				if (status.last_voxel) begin
					state_nxt = vcar_pkg::ST_DRAIN;
				end
			end
			vcar_pkg::ST_DRAIN: begin
				state_nxt = vcar_pkg::ST_FINISH;
			end
			vcar_pkg::ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					state_nxt = vcar_pkg::ST_IDLE;
				end
			end
			default: state_nxt = vcar_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			vcar_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load      = s_axis_tvalid;
			end
			vcar_pkg::ST_VISIT: begin
				cmd.visit = 1'b1;
			end
			vcar_pkg::ST_DRAIN: begin
			end
			vcar_pkg::ST_FINISH: begin
				cmd.publish = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;

	a_bad_skips_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && status.req_bad) |=> (state_q == vcar_pkg::ST_FINISH))
		else $error("bad request did not go straight to finish");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vcar_pkg::ST_VISIT && status.last_voxel) |=>
		(state_q == vcar_pkg::ST_DRAIN))
		else $error("voxel walk did not end after the last voxel");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> m_axis_tvalid)
		else $error("published result not presented");

endmodule

FILE: sv/vcar_dp.sv
// ----------------------------------------------------------------------------
// vcar_dp
// Datapath: voxel counter, two-stage rotate/round pipeline, target map.
// ----------------------------------------------------------------------------
module vcar_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vcar_pkg::cmd_t       cmd,
	output vcar_pkg::status_t    status,
	input  logic [63:0]          source_map,
	input  logic [1:0]           func,
	input  logic [3:0]           angle,
	output logic [63:0]          result_map,
	output logic                 bad_request
);

	logic [63:0]                          src_q;
	logic [63:0]                          accum_q;
	logic [5:0]                           cnt_q;
	logic                                 bad_q;
	vcar_pkg::axis_t                      axis_q;
	logic signed [vcar_pkg::COEF_W-1:0]   cos_q;
	logic signed [vcar_pkg::COEF_W-1:0]   sin_e_q;
	logic [63:0]                          res_map_q;
	logic                                 res_bad_q;

	logic                                 hit_s1;
	logic signed [vcar_pkg::SUM_W-1:0]    sum_a_s1;
	logic signed [vcar_pkg::SUM_W-1:0]    sum_b_s1;
	logic [1:0]                           x_s1;
	logic [1:0]                           y_s1;
	logic [1:0]                           z_s1;

	logic signed [vcar_pkg::COEF_W-1:0]   sin_in;
	logic signed [2:0]                    dx;
	logic signed [2:0]                    dy;
	logic signed [2:0]                    dz;
	logic signed [2:0]                    d1;
	logic signed [2:0]                    d2;
	logic signed [vcar_pkg::SUM_W-1:0]    sum_a;
	logic signed [vcar_pkg::SUM_W-1:0]    sum_b;
	logic [1:0]                           qa;
	logic [1:0]                           qb;
	logic [1:0]                           nx;
	logic [1:0]                           ny;
	logic [1:0]                           nz;

	// S = sum + 1.5, coordinate = round-half-away(S) clamped to 0..3
	function automatic logic [1:0] round_clamp(input logic signed [vcar_pkg::SUM_W-1:0] sum);
		logic signed [vcar_pkg::ACC_W-1:0] s;
		logic        [vcar_pkg::ACC_W-1:0] r;
		logic        [vcar_pkg::Q_W-1:0]   q;
		logic        [1:0]                 c;
		s = vcar_pkg::ACC_W'(sum) + vcar_pkg::ACC_CENTER;
		r = unsigned'(s + vcar_pkg::ACC_ROUND);
		q = r[vcar_pkg::ACC_W-1:vcar_pkg::COEF_FRACTION_BITS+1];
		if (s[vcar_pkg::ACC_W-1]) begin
			c = 2'd0;
		end else if (q > vcar_pkg::Q_W'(3)) begin
			c = 2'd3;
		end else begin
			c = q[1:0];
		end
		return c;
	endfunction

	assign status.req_bad    = (func == vcar_pkg::AXIS_BAD) || (angle > vcar_pkg::ANGLE_MAX);
	assign status.last_voxel = (cnt_q == vcar_pkg::LAST_VOXEL);

	assign sin_in = vcar_pkg::coef_of(vcar_pkg::cos_code(vcar_pkg::sin_index(angle)));

	// half-unit offsets: 2c - 3
	assign dx = $signed({~cnt_q[1], cnt_q[0], 1'b1});
	assign dy = $signed({~cnt_q[3], cnt_q[2], 1'b1});
	assign dz = $signed({~cnt_q[5], cnt_q[4], 1'b1});

	assign d1 = (axis_q == vcar_pkg::AXIS_X) ? dy : dx;
	assign d2 = (axis_q == vcar_pkg::AXIS_Z) ? dy : dz;

	assign sum_a = vcar_pkg::SUM_W'(cos_q) * vcar_pkg::SUM_W'(d1)
		+ vcar_pkg::SUM_W'(sin_e_q) * vcar_pkg::SUM_W'(d2);
	assign sum_b = vcar_pkg::SUM_W'(cos_q) * vcar_pkg::SUM_W'(d2)
		- vcar_pkg::SUM_W'(sin_e_q) * vcar_pkg::SUM_W'(d1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q   <= source_map;
			bad_q   <= status.req_bad;
			axis_q  <= vcar_pkg::axis_t'(func);
			cos_q   <= vcar_pkg::coef_of(vcar_pkg::cos_code(angle));
			sin_e_q <= (func == vcar_pkg::AXIS_Y) ? sin_in : -sin_in;
		end
		sum_a_s1 <= sum_a;
		sum_b_s1 <= sum_b;
		x_s1     <= cnt_q[1:0];
		y_s1     <= cnt_q[3:2];
		z_s1     <= cnt_q[5:4];
		if (cmd.publish) begin
			res_map_q <= accum_q;
			res_bad_q <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hit_s1  <= 1'b0;
			accum_q <= '0;
		end else begin
			hit_s1 <= cmd.visit && src_q[cnt_q];
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.visit) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.load) begin
				accum_q <= '0;
			end else if (hit_s1) begin
				accum_q[{nz, ny, nx}] <= 1'b1;
			end
		end
	end

	assign qa = round_clamp(sum_a_s1);
	assign qb = round_clamp(sum_b_s1);

	always_comb begin
		nx = x_s1;
		ny = y_s1;
		nz = z_s1;
		case (axis_q)
			vcar_pkg::AXIS_X: begin
				ny = qa;
				nz = qb;
			end
			vcar_pkg::AXIS_Y: begin
				nx = qa;
				nz = qb;
			end
			default: begin
				nx = qa;
				ny = qb;
			end
		endcase
	end

	assign result_map  = res_map_q;
	assign bad_request = res_bad_q;

endmodule

FILE: sv/voxel_cube_axis_rotate_top.sv
// ----------------------------------------------------------------------------
// voxel_cube_axis_rotate_top
// Rotates a 4x4x4 voxel map about the X, Y or Z axis in 30 degree steps.
// ----------------------------------------------------------------------------
// Flow: each request visits all 64 voxels, drains the pipeline, then
//   publishes the result; a bad request skips the walk and the drain.
// The single rotate unit visits one voxel per cycle; one request is in
//   flight at a time.
// Reset: arst_n clears the sequencer, voxel counter, target map and output
//   valid at once; no clearing pass.
module voxel_cube_axis_rotate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // source_map[63:0], angle[67:64], zero pad
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // result_map[63:0]
	output logic [0:0]  m_axis_tuser    // bad_request[0]
);

	vcar_pkg::cmd_t    cmd;
	vcar_pkg::status_t status;
	logic              bad_request;

	vcar_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	vcar_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.source_map  (s_axis_tdata[63:0]),
		.func        (s_axis_tuser),
		.angle       (s_axis_tdata[67:64]),
		.result_map  (m_axis_tdata),
		.bad_request (bad_request)
	);

	assign m_axis_tuser = bad_request;

endmodule

FILE: tb/voxel_cube_axis_rotate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_cube_axis_rotate_top_tb
// Streams voxel maps with rotation requests through the rotator and checks
// every returned map and bad_request flag against an in-bench rotation model:
// a directed table of corner cases first, then about 550 random requests,
// with random idling on both stream sides.
// ----------------------------------------------------------------------------
module voxel_cube_axis_rotate_top_tb;
	import vcar_pkg::*;

	localparam longint UNIT = longint'(1) << COEF_FRACTION_BITS;
	localparam longint ROOT3_HALF = (866 * UNIT + 500) / 1000;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int N_PROBES = 22;

	typedef struct packed {
		logic [63:0] map;
		logic        bad;
	} rotated_t;

	typedef struct packed {
		logic [63:0] src;
		axis_t       axis;
		logic [3:0]  angle;
		logic        typed;
		logic [63:0] want_map;
		logic        want_bad;
	} probe_row_t;

	localparam logic [63:0] ALL_LIT = 64'hFFFF_FFFF_FFFF_FFFF;

	// typed rows: empty source, identity at angle 0, bad requests
	localparam probe_row_t PROBES [N_PROBES] = '{
		'{64'h0, AXIS_X, 4'd0, 1'b1, 64'h0, 1'b0},
		'{ALL_LIT, AXIS_X, 4'd0, 1'b1, ALL_LIT, 1'b0},
		'{ALL_LIT, AXIS_Y, 4'd0, 1'b1, ALL_LIT, 1'b0},
		'{ALL_LIT, AXIS_Z, 4'd0, 1'b1, ALL_LIT, 1'b0},
		'{64'hDEAD_BEEF_0BAD_F00D, AXIS_Z, 4'd0, 1'b1, 64'hDEAD_BEEF_0BAD_F00D, 1'b0},
		'{ALL_LIT, AXIS_BAD, 4'd0, 1'b1, 64'h0, 1'b1},
		'{ALL_LIT, AXIS_X, 4'd12, 1'b1, 64'h0, 1'b1},
		'{ALL_LIT, AXIS_Z, 4'd15, 1'b1, 64'h0, 1'b1},
		'{64'h0, AXIS_BAD, 4'd15, 1'b1, 64'h0, 1'b1},
		'{64'h0, AXIS_Z, 4'd11, 1'b1, 64'h0, 1'b0},
		'{64'h0000_0000_0000_0001, AXIS_X, 4'd1, 1'b0, 64'h0, 1'b0},
		'{64'h8000_0000_0000_0000, AXIS_Y, 4'd5, 1'b0, 64'h0, 1'b0},
		'{64'h0123_4567_89AB_CDEF, AXIS_X, 4'd3, 1'b0, 64'h0, 1'b0},
		'{64'hFEDC_BA98_7654_3210, AXIS_Y, 4'd6, 1'b0, 64'h0, 1'b0},
		'{64'h5555_5555_5555_5555, AXIS_Z, 4'd9, 1'b0, 64'h0, 1'b0},
		'{64'hAAAA_AAAA_AAAA_AAAA, AXIS_X, 4'd2, 1'b0, 64'h0, 1'b0},
		'{64'h0000_0000_0000_FFFF, AXIS_Y, 4'd4, 1'b0, 64'h0, 1'b0},
		'{ALL_LIT, AXIS_Z, 4'd7, 1'b0, 64'h0, 1'b0},
		'{ALL_LIT, AXIS_X, 4'd8, 1'b0, 64'h0, 1'b0},
		'{64'h8421_1248_8421_1248, AXIS_Y, 4'd10, 1'b0, 64'h0, 1'b0},
		'{64'h0660_0660_0660_0660, AXIS_Z, 4'd11, 1'b0, 64'h0, 1'b0},
		'{64'h9009_0000_0000_9009, AXIS_X, 4'd5, 1'b0, 64'h0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;    // source_map[63:0], angle[67:64], zero pad
	logic [1:0]  s_axis_tuser;    // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;    // result_map[63:0]
	logic [0:0]  m_axis_tuser;    // bad_request[0]

	rotated_t    pending_maps [$];
	int unsigned mismatch_count;
	int unsigned stalled_cycles;
	bit          calm;

	voxel_cube_axis_rotate_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// cosine of step*30 degrees
	function automatic longint trig_coef(input int unsigned step);
		longint c;
		case (step % 12)
			0:       c = UNIT;
			1, 11:   c = ROOT3_HALF;
			2, 10:   c = UNIT / 2;
			4, 8:    c = -(UNIT / 2);
			5, 7:    c = -ROOT3_HALF;
			6:       c = -UNIT;
			default: c = 0;
		endcase
		return c;
	endfunction

	// a*d1 + b*d2 + 1.5 in half units, rounded away from zero, clamped to 0..3
	function automatic int unsigned snap_coord(input longint a, input longint d1,
			input longint b, input longint d2);
		longint sum;
		longint q;
		sum = a * d1 + b * d2 + 3 * UNIT;
		if (sum < 0) begin
			return 0;
		end
		q = (sum + UNIT) >>> (COEF_FRACTION_BITS + 1);
		return (q > 3) ? 3 : int'(q);
	endfunction

	function automatic rotated_t rotate_cube(input logic [63:0] src, input axis_t axis,
			input logic [3:0] ang);
		rotated_t    r;
		longint      cs;
		longint      sn;
		longint      dx;
		longint      dy;
		longint      dz;
		int unsigned nx;
		int unsigned ny;
		int unsigned nz;
		r.map = '0;
		r.bad = (axis == AXIS_BAD) || (ang > 4'd11);
		if (!r.bad) begin
			cs = trig_coef(int'(ang));
			sn = trig_coef(int'(ang) + 9);
			for (int v = 0; v < 64; v++) begin
				nx = v % 4;
				ny = (v / 4) % 4;
				nz = v / 16;
				dx = 2 * longint'(nx) - 3;
				dy = 2 * longint'(ny) - 3;
				dz = 2 * longint'(nz) - 3;
				if (src[v]) begin
					case (axis)
						AXIS_X: begin
							ny = snap_coord(cs, dy, -sn, dz);
							nz = snap_coord(sn, dy, cs, dz);
						end
						AXIS_Y: begin
							nx = snap_coord(cs, dx, sn, dz);
							nz = snap_coord(-sn, dx, cs, dz);
						end
						default: begin
							nx = snap_coord(cs, dx, -sn, dy);
							ny = snap_coord(sn, dx, cs, dy);
						end
					endcase
					r.map[nz * 16 + ny * 4 + nx] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic offer_request(input logic [63:0] src, input axis_t axis,
			input logic [3:0] ang, input logic typed, input logic [63:0] want_map,
			input logic want_bad);
		rotated_t outcome;
		while (!calm && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, ang, src};
		s_axis_tuser  <= axis;
		forever begin
			@(posedge clk);
			if (s_axis_tready === 1'b1) break;
		end
		if (typed) begin
			outcome.map = want_map;
			outcome.bad = want_bad;
		end else begin
			outcome = rotate_cube(src, axis, ang);
		end
		pending_maps.push_back(outcome);
		@(negedge clk);
	endtask

	task automatic check_result(input logic [63:0] got_map, input logic got_bad);
		rotated_t want;
		if (pending_maps.size() == 0) begin
			$display("%0t: unexpected transaction map=%h bad=%b", $time, got_map, got_bad);
			mismatch_count++;
			return;
		end
		want = pending_maps.pop_front();
		if (got_map !== want.map) begin
			$display("%0t: result_map expected %h actual %h", $time, want.map, got_map);
			mismatch_count++;
		end
		if (got_bad !== want.bad) begin
			$display("%0t: bad_request expected %b actual %b", $time, want.bad, got_bad);
			mismatch_count++;
		end
	endtask

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata, m_axis_tuser[0]);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				stalled_cycles <= 0;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	initial begin
		wait (stalled_cycles >= STALL_LIMIT);
		$display("voxel_cube_axis_rotate_top: mismatch");
		$finish;
	end

	initial begin
		logic [63:0] src;
		axis_t       axis;
		logic [3:0]  ang;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		m_axis_tready  = 1'b0;
		mismatch_count = 0;
		stalled_cycles = 0;
		calm           = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_PROBES; i++) begin
			offer_request(PROBES[i].src, PROBES[i].axis, PROBES[i].angle, PROBES[i].typed,
				PROBES[i].want_map, PROBES[i].want_bad);
		end

		for (int i = 0; i < 550; i++) begin
			calm = (i >= 300) && (i < 400);
			case ($urandom_range(9))
				0, 1, 2, 3, 4: src = {$urandom, $urandom};
				5, 6: begin
					src = '0;
					repeat ($urandom_range(3, 1)) src[$urandom_range(63)] = 1'b1;
				end
				7: src = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
				8: src = $urandom_range(1) ? ALL_LIT : 64'h0;
				default: src = {$urandom, $urandom} & {$urandom, $urandom};
			endcase
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(1)) begin
					axis = AXIS_BAD;
					ang  = 4'($urandom_range(15));
				end else begin
					axis = axis_t'($urandom_range(3));
					ang  = 4'($urandom_range(15, 12));
				end
			end else begin
				axis = axis_t'($urandom_range(2));
				ang  = 4'($urandom_range(11));
			end
			offer_request(src, axis, ang, 1'b0, 64'h0, 1'b0);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		wait (pending_maps.size() == 0);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("voxel_cube_axis_rotate_top: match");
		end else begin
			$display("voxel_cube_axis_rotate_top: mismatch");
		end
		$finish;
	end

endmodule
